// ===== rtl/ipv4dq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ipv4dq_pkg;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_DOT  = 8'h2E;
	localparam logic [7:0] COUNT_MAX = 8'hFF;
	localparam logic [11:0] OCTET_MAX = 12'd255;
	localparam logic [1:0] LAST_OCTET = 2'd3;

	typedef struct packed {
		logic        scanning;
		logic [1:0]  octet_idx;
		logic [7:0]  acc;
		logic        digit_seen;
		logic [23:0] done_octets;
		logic [7:0]  count;
	} scan_state_t;

	localparam scan_state_t SCAN_IDLE = '{
		scanning: 1'b0, octet_idx: 2'd0, acc: 8'd0, digit_seen: 1'b0,
		done_octets: 24'd0, count: 8'd0
	};

endpackage
`default_nettype wire

// ===== rtl/ipv4_dotted_quad_scanner.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Dotted-decimal IPv4 address scanner, one character per transaction.
// Input channel: in_valid/in_stall carrying start_req and char_in. start_req=1
// opens a new scan with char_in as its first character (any scan in progress
// is dropped). Characters seen while no scan is open are ignored.
// Output channel: out_valid/out_stall carrying ok, address and length. One
// result is given per scan, when the first non-digit after the fourth octet
// arrives, when a non-dot ends a first octet of zero, or at the first error;
// failures show address and length as zero. A character passes through the
// input register, then the result register. Throughput: one character per
// cycle unless the receiver stalls; the scan state loop (multiply-by-ten
// accumulate and a compare) is combinational around the scan state register.
// When the receiver stalls, the result is held; the input register keeps
// taking characters until it holds one that cannot advance, then in_stall
// rises. Reset (arst_n low) closes any scan and empties both registers.
module ipv4_dotted_quad_scanner (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        start_req,
	input  wire logic [7:0]  char_in,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             ok,
	output logic [31:0]      address,
	output logic [7:0]       length
);

	logic        valid_s1;
	logic        start_s1;
	logic [7:0]  char_s1;

	ipv4dq_pkg::scan_state_t scan_q;
	ipv4dq_pkg::scan_state_t st;
	ipv4dq_pkg::scan_state_t scan_next;

	logic        out_valid_q;
	logic        ok_q;
	logic [31:0] address_q;
	logic [7:0]  length_q;

	logic        advance;
	logic        is_digit;
	logic [3:0]  digit;
	logic [11:0] acc_next;
	logic [7:0]  count_inc;
	logic        res_valid;
	logic        res_ok;
	logic [31:0] res_addr;

	// the held character may move on only when the result slot is free
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			start_s1 <= start_req;
			char_s1  <= char_in;
		end
	end

	always_comb begin
		st = start_s1 ? ipv4dq_pkg::SCAN_IDLE : scan_q;
		if (start_s1) begin
			st.scanning = 1'b1;
		end
		is_digit  = (char_s1 >= ipv4dq_pkg::CHAR_ZERO) && (char_s1 <= ipv4dq_pkg::CHAR_NINE);
		digit     = 4'(char_s1 - ipv4dq_pkg::CHAR_ZERO);
		acc_next  = {1'b0, st.acc, 3'b000} + {3'b000, st.acc, 1'b0} + {8'd0, digit};
		count_inc = (st.count == ipv4dq_pkg::COUNT_MAX) ? st.count : st.count + 8'd1;

		scan_next = st;
		res_valid = 1'b0;
		res_ok    = 1'b0;
		res_addr  = 32'd0;

		if (st.scanning) begin
			if (is_digit) begin
				if (acc_next > ipv4dq_pkg::OCTET_MAX) begin
					res_valid = 1'b1;
				end else begin
					scan_next.acc        = acc_next[7:0];
					scan_next.digit_seen = 1'b1;
					scan_next.count      = count_inc;
				end
			end else if (!st.digit_seen) begin
				res_valid = 1'b1;
			end else if (st.octet_idx != ipv4dq_pkg::LAST_OCTET) begin
				if (char_s1 == ipv4dq_pkg::CHAR_DOT) begin
					scan_next.done_octets = {st.done_octets[15:0], st.acc};
					scan_next.octet_idx   = st.octet_idx + 2'd1;
					scan_next.acc         = 8'd0;
					scan_next.digit_seen  = 1'b0;
					scan_next.count       = count_inc;
				end else begin
					// a lone zero first octet stands for 0.0.0.0
					res_valid = 1'b1;
					res_ok    = (st.octet_idx == 2'd0) && (st.acc == 8'd0);
				end
			end else begin
				res_valid = 1'b1;
				res_ok    = 1'b1;
				res_addr  = {st.done_octets, st.acc};
			end
			if (res_valid) begin
				scan_next.scanning = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q      <= ipv4dq_pkg::SCAN_IDLE;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res_valid;
			if (valid_s1) begin
				scan_q <= scan_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_valid) begin
			ok_q      <= res_ok;
			address_q <= res_ok ? res_addr : 32'd0;
			length_q  <= res_ok ? st.count : 8'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign address   = address_q;
	assign length    = length_q;

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> address == 32'd0 && length == 8'd0)
		else $error("failed scan reports nonzero fields");

	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ok |-> length != 8'd0)
		else $error("good scan with zero length");

	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s1 && res_valid |=> !scan_q.scanning && out_valid_q)
		else $error("scan stays open after its result");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked result");

endmodule
`default_nettype wire
